// ===== sv/ltes_pkg.sv =====
// shared constants, codes and controller/datapath interface types
package ltes_pkg;

  localparam int NUM_TRACKS       = 4;
  localparam int EVENTS_PER_TRACK = 64;
  localparam int TRK_W            = 2;
  localparam int SLOT_W           = 6;
  localparam int CNT_W            = 7;
  localparam int ADDR_W           = TRK_W + SLOT_W;
  localparam int TIME_W           = 48;
  localparam int LEN_W            = 32;
  localparam int TAG_W            = 16;
  localparam int ACT_W            = 4;

  localparam logic [ACT_W-1:0] ACT_LOAD      = 4'd0;
  localparam logic [ACT_W-1:0] ACT_LENGTH    = 4'd1;
  localparam logic [ACT_W-1:0] ACT_RESTART   = 4'd2;
  localparam logic [ACT_W-1:0] ACT_START_ALL = 4'd3;
  localparam logic [ACT_W-1:0] ACT_STOP_ALL  = 4'd4;
  localparam logic [ACT_W-1:0] ACT_START     = 4'd5;
  localparam logic [ACT_W-1:0] ACT_STOP      = 4'd6;
  localparam logic [ACT_W-1:0] ACT_RESET     = 4'd7;
  localparam logic [ACT_W-1:0] ACT_ADVANCE   = 4'd8;
  localparam logic [ACT_W-1:0] ACT_POLL      = 4'd9;

  localparam logic [1:0] CFG_AUTO_MASK = 2'd0;
  localparam logic [1:0] CFG_MAX_WAIT  = 2'd1;

  typedef struct packed {
    logic              latch;
    logic              exec;
    logic              rst_init;
    logic              div_start;
    logic              rd;
    logic              rd_scan;
    logic              set_cursor;
    logic              cursor_zero;
    logic              fire;
    logic              wait_eval;
    logic              out_load;
    logic [TRK_W-1:0]  trk;
    logic [SLOT_W-1:0] scan;
  } ltes_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             div_busy;
    logic             eligible;
    logic             hit;
    logic             scan_ge;
    logic [CNT_W-1:0] count;
    logic             out_free;
  } ltes_sts_t;

endpackage

// ===== sv/ltes_div.sv =====
// restoring divider, one quotient bit per cycle
module ltes_div import ltes_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [TIME_W-1:0] dividend,
  input  logic [LEN_W-1:0]  divisor,
  output logic              busy,
  output logic [TIME_W-1:0] quot,
  output logic [LEN_W-1:0]  rem
);

  localparam int CW = $clog2(TIME_W);

  logic [CW-1:0]     cnt;
  logic [TIME_W-1:0] dvd;
  logic [LEN_W-1:0]  part;
  logic [LEN_W-1:0]  dvs;
  logic [LEN_W:0]    tmp;
  logic [LEN_W:0]    diff;
  logic              ge;

  assign tmp  = {part, dvd[TIME_W-1]};
  assign diff = tmp - {1'b0, dvs};
  assign ge   = tmp >= {1'b0, dvs};
  assign quot = dvd;
  assign rem  = part;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(TIME_W - 1);
      dvd  <= dividend;
      part <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      part <= ge ? diff[LEN_W-1:0] : tmp[LEN_W-1:0];
      dvd  <= {dvd[TIME_W-2:0], ge};
      cnt  <= cnt - 1'b1;
      if (cnt == '0) busy <= 1'b0;
    end
  end

endmodule

// ===== sv/ltes_ctrl.sv =====
// sequencer for actions, restart scan, poll and wait passes
module ltes_ctrl import ltes_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ltes_sts_t sts,
  output ltes_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_RINIT, S_RDIV, S_RWAIT, S_RRD, S_RCMP,
    S_CHK, S_DWAIT, S_EVAL, S_FIN
  } state_t;

  state_t            state;
  logic [TRK_W-1:0]  trk;
  logic [SLOT_W-1:0] scan;
  logic              phase_poll;
  logic              last_trk;
  logic [CNT_W-1:0]  scan_inc;

  assign last_trk = trk == TRK_W'(NUM_TRACKS - 1);
  assign scan_inc = {1'b0, scan} + 1'b1;
  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd             = '0;
    cmd.trk         = trk;
    cmd.scan        = scan;
    cmd.latch       = (state == S_IDLE) && in_valid;
    cmd.exec        = state == S_EXEC;
    cmd.rst_init    = state == S_RINIT;
    cmd.div_start   = (state == S_RDIV) || ((state == S_CHK) && sts.eligible);
    cmd.rd          = (state == S_RRD) || ((state == S_CHK) && sts.eligible);
    cmd.rd_scan     = state == S_RRD;
    cmd.fire        = (state == S_EVAL) && phase_poll && sts.hit;
    cmd.wait_eval   = (state == S_EVAL) && !phase_poll;
    cmd.out_load    = (state == S_FIN) && sts.out_free;
    case (state)
      S_RWAIT: begin
        if (!sts.div_busy && sts.count == '0) begin
          cmd.set_cursor  = 1'b1;
          cmd.cursor_zero = 1'b1;
        end
      end
      S_RCMP: begin
        if (sts.scan_ge) begin
          cmd.set_cursor = 1'b1;
        end else if (scan_inc >= sts.count) begin
          cmd.set_cursor  = 1'b1;
          cmd.cursor_zero = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      trk        <= '0;
      scan       <= '0;
      phase_poll <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          trk        <= '0;
          phase_poll <= sts.act == ACT_POLL;
          if (sts.act == ACT_RESTART) state <= S_RINIT;
          else                        state <= S_CHK;
        end
        S_RINIT: state <= S_RDIV;
        S_RDIV:  state <= S_RWAIT;
        S_RWAIT: begin
          if (!sts.div_busy) begin
            scan <= '0;
            if (sts.count == '0) begin
              if (last_trk) begin
                trk   <= '0;
                state <= S_CHK;
              end else begin
                trk   <= trk + 1'b1;
                state <= S_RDIV;
              end
            end else begin
              state <= S_RRD;
            end
          end
        end
        S_RRD: state <= S_RCMP;
        S_RCMP: begin
          if (sts.scan_ge || scan_inc >= sts.count) begin
            if (last_trk) begin
              trk   <= '0;
              state <= S_CHK;
            end else begin
              trk   <= trk + 1'b1;
              state <= S_RDIV;
            end
          end else begin
            scan  <= scan_inc[SLOT_W-1:0];
            state <= S_RRD;
          end
        end
        S_CHK: begin
          if (sts.eligible) begin
            state <= S_DWAIT;
          end else if (last_trk) begin
            trk <= '0;
            if (phase_poll) phase_poll <= 1'b0;
            else            state      <= S_FIN;
          end else begin
            trk <= trk + 1'b1;
          end
        end
        S_DWAIT: begin
          if (!sts.div_busy) state <= S_EVAL;
        end
        S_EVAL: begin
          state <= S_CHK;
          if (phase_poll && sts.hit) begin
            trk        <= '0;
            phase_poll <= 1'b0;
          end else if (last_trk) begin
            trk <= '0;
            if (phase_poll) phase_poll <= 1'b0;
            else            state      <= S_FIN;
          end else begin
            trk <= trk + 1'b1;
          end
        end
        S_FIN: begin
          if (sts.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/ltes_dp.sv =====
// track state, event memory, divider and result register
module ltes_dp import ltes_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ltes_cmd_t         cmd,
  output ltes_sts_t         sts,
  input  logic [ACT_W-1:0]  in_act,
  input  logic [TRK_W-1:0]  in_trk,
  input  logic [SLOT_W-1:0] in_slot,
  input  logic [LEN_W-1:0]  in_ts,
  input  logic [TAG_W-1:0]  in_tag,
  input  logic              in_last,
  input  logic [LEN_W-1:0]  in_len,
  input  logic [TIME_W-1:0] in_now,
  input  logic              in_keep,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_idx,
  input  logic [LEN_W-1:0]  cfg_val,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_ev_valid,
  output logic [TRK_W-1:0]  out_trk,
  output logic [SLOT_W-1:0] out_slot,
  output logic [TAG_W-1:0]  out_tag,
  output logic [LEN_W-1:0]  out_wait
);

  logic [NUM_TRACKS-1:0]   auto_mask;
  logic [LEN_W-1:0]        max_wait;
  logic [TIME_W-1:0]       cur;

  logic [CNT_W-1:0]        count    [NUM_TRACKS];
  logic [LEN_W-1:0]        loop_len [NUM_TRACKS];
  logic [SLOT_W-1:0]       cursor   [NUM_TRACKS];
  logic [TIME_W-1:0]       lap      [NUM_TRACKS];
  logic [NUM_TRACKS-1:0]   running;
  logic [NUM_TRACKS-1:0]   resume;
  logic [TIME_W-1:0]       stamp    [NUM_TRACKS];
  logic [TIME_W-1:0]       total    [NUM_TRACKS];

  logic [ACT_W-1:0]        act_q;
  logic [TRK_W-1:0]        trk_q;
  logic [SLOT_W-1:0]       slot_q;
  logic [LEN_W-1:0]        ts_q;
  logic [TAG_W-1:0]        tag_q;
  logic                    last_q;
  logic [LEN_W-1:0]        len_q;

  logic [LEN_W+TAG_W-1:0]  mem [NUM_TRACKS*EVENTS_PER_TRACK];
  logic [LEN_W+TAG_W-1:0]  mem_q;
  logic [ADDR_W-1:0]       raddr;

  logic                    res_valid;
  logic [TRK_W-1:0]        res_trk;
  logic [SLOT_W-1:0]       res_slot;
  logic [TAG_W-1:0]        res_tag;
  logic [LEN_W-1:0]        best;

  logic [TIME_W-1:0]       el_sel;
  logic                    div_busy;
  logic [TIME_W-1:0]       quot;
  logic [LEN_W-1:0]        rem;
  logic [LEN_W-1:0]        m_ts;
  logic [TAG_W-1:0]        m_tag;
  logic                    lap_eq;
  logic                    lap_next;
  logic [LEN_W+1:0]        cand_a;
  logic [LEN_W-1:0]        cand_b;
  logic [CNT_W-1:0]        cur_inc;
  logic                    tok;

  assign m_ts    = mem_q[LEN_W-1:0];
  assign m_tag   = mem_q[LEN_W+TAG_W-1:LEN_W];
  assign el_sel  = running[cmd.trk] ? total[cmd.trk] + (cur - stamp[cmd.trk])
                                    : total[cmd.trk];
  assign lap_eq   = lap[cmd.trk] == quot;
  assign lap_next = (cursor[cmd.trk] == '0) && (lap[cmd.trk] == quot + 1'b1);
  assign cand_a   = {2'b00, m_ts} + {2'b00, loop_len[cmd.trk]} - {2'b00, rem};
  assign cand_b   = m_ts - rem;
  assign cur_inc  = {1'b0, cursor[cmd.trk]} + 1'b1;
  assign tok      = 32'(trk_q) < NUM_TRACKS;
  assign raddr    = {cmd.trk, cmd.rd_scan ? cmd.scan : cursor[cmd.trk]};

  ltes_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (el_sel),
    .divisor  (loop_len[cmd.trk]),
    .busy     (div_busy),
    .quot     (quot),
    .rem      (rem)
  );

  always_comb begin
    sts          = '0;
    sts.act      = act_q;
    sts.div_busy = div_busy;
    sts.eligible = ({1'b0, cursor[cmd.trk]} < count[cmd.trk]) && running[cmd.trk];
    sts.hit      = (m_ts <= rem) && lap_eq;
    sts.scan_ge  = m_ts >= rem;
    sts.count    = count[cmd.trk];
    sts.out_free = !out_valid || out_ready;
  end

  // event memory, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.exec && act_q == ACT_LOAD && tok && 32'(slot_q) < EVENTS_PER_TRACK)
      mem[{trk_q, slot_q}] <= {tag_q, ts_q};
    if (cmd.rd) mem_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_q  <= in_act;
      trk_q  <= in_trk;
      slot_q <= in_slot;
      ts_q   <= in_ts;
      tag_q  <= in_tag;
      last_q <= in_last;
      len_q  <= in_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_mask <= '0;
      max_wait  <= LEN_W'(1000);
      cur       <= '0;
      running   <= '0;
      resume    <= '0;
      out_valid <= 1'b0;
      res_valid <= 1'b0;
      for (int k = 0; k < NUM_TRACKS; k++) begin
        count[k]    <= '0;
        loop_len[k] <= LEN_W'(1);
        cursor[k]   <= '0;
        lap[k]      <= '0;
        stamp[k]    <= '0;
        total[k]    <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_AUTO_MASK: auto_mask <= cfg_val[NUM_TRACKS-1:0];
          CFG_MAX_WAIT:  max_wait  <= cfg_val;
          default: ;
        endcase
      end
      if (cmd.latch && !in_keep) cur <= in_now;

      if (cmd.exec) begin
        res_valid <= 1'b0;
        res_trk   <= '0;
        res_slot  <= '0;
        res_tag   <= '0;
        best      <= max_wait;
        case (act_q)
          ACT_LOAD: begin
            if (tok && last_q && 32'(slot_q) < EVENTS_PER_TRACK)
              count[trk_q] <= {1'b0, slot_q} + 1'b1;
          end
          ACT_LENGTH: begin
            if (tok) loop_len[trk_q] <= (len_q == '0) ? LEN_W'(1) : len_q;
          end
          ACT_START_ALL: begin
            for (int k = 0; k < NUM_TRACKS; k++) begin
              if (resume[k] && !running[k]) begin
                running[k] <= 1'b1;
                stamp[k]   <= cur;
              end
            end
          end
          ACT_STOP_ALL: begin
            resume <= running;
            for (int k = 0; k < NUM_TRACKS; k++) begin
              if (running[k]) begin
                running[k] <= 1'b0;
                total[k]   <= total[k] + (cur - stamp[k]);
              end
            end
          end
          ACT_START: begin
            if (tok && !running[trk_q]) begin
              running[trk_q] <= 1'b1;
              stamp[trk_q]   <= cur;
            end
          end
          ACT_STOP: begin
            if (tok && running[trk_q]) begin
              running[trk_q] <= 1'b0;
              total[trk_q]   <= total[trk_q] + (cur - stamp[trk_q]);
            end
          end
          ACT_RESET: begin
            if (tok) begin
              running[trk_q] <= auto_mask[trk_q];
              total[trk_q]   <= '0;
              stamp[trk_q]   <= auto_mask[trk_q] ? cur : '0;
              lap[trk_q]     <= '0;
              cursor[trk_q]  <= '0;
            end
          end
          default: ;
        endcase
      end

      // restart: tracks in the auto start mask run, and every track's stamp takes the current time
      if (cmd.rst_init) begin
        running <= auto_mask;
        resume  <= auto_mask;
        for (int k = 0; k < NUM_TRACKS; k++) stamp[k] <= cur;
      end

      if (cmd.set_cursor) begin
        cursor[cmd.trk] <= cmd.cursor_zero ? '0 : cmd.scan;
        lap[cmd.trk]    <= quot;
      end

      if (cmd.fire) begin
        res_valid <= 1'b1;
        res_trk   <= cmd.trk;
        res_slot  <= cursor[cmd.trk];
        res_tag   <= m_tag;
        if (cur_inc == count[cmd.trk]) begin
          cursor[cmd.trk] <= '0;
          lap[cmd.trk]    <= lap[cmd.trk] + 1'b1;
        end else begin
          cursor[cmd.trk] <= cur_inc[SLOT_W-1:0];
        end
      end

      if (cmd.wait_eval) begin
        if (lap_next) begin
          if (cand_a < {2'b00, best}) best <= cand_a[LEN_W-1:0];
        end else if (m_ts >= rem && lap_eq) begin
          if (cand_b < best) best <= cand_b;
        end
      end

      if (cmd.out_load) begin
        out_valid    <= 1'b1;
        out_ev_valid <= res_valid;
        out_trk      <= res_trk;
        out_slot     <= res_slot;
        out_tag      <= res_tag;
        out_wait     <= best;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/looping_track_event_scheduler_unit.sv =====
// top level of the looping track event scheduler
//
// usage
// - slave stream: one transaction carries one action; tuser holds action and
//   track, tlast marks the last loaded event, tdata the remaining fields
// - master stream: exactly one result transaction per action, with the
//   event flag in tuser and track, slot, tag and wait time in tdata
// - config channel: cfg_index 0 auto start mask, 1 max wait; write only
//   while the block is idle, cfg_ready is always high
// - flow: an action is latched and executed, then a wait pass visits each
//   track, with one serial division for a running track with a pending
//   event; a poll first runs a pass of the same kind that stops at the first
//   due event; a restart adds an init step plus per track a division and a
//   scan of the slots for the first event past the offset
// - one action at a time; a new one is taken only when the sequencer idles
// - reset: all tracks stopped, loop length 1, no events, max wait 1000;
//   the event memory holds no reset value
// - a stalled master holds the result; the next action is taken meanwhile
//   and its result waits in the datapath until the output register frees
module looping_track_event_scheduler_unit import ltes_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // event_index, timestamp, event_tag, track_length, now, keep_time, zero pad
  input  logic [135:0] s_tdata,
  // action, track
  input  logic [5:0]   s_tuser,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // event_track, event_slot, fired_tag, wait_time
  output logic [55:0]  m_tdata,
  // event_valid
  output logic         m_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  ltes_cmd_t         cmd;
  ltes_sts_t         sts;
  logic [TRK_W-1:0]  o_trk;
  logic [SLOT_W-1:0] o_slot;
  logic [TAG_W-1:0]  o_tag;
  logic [LEN_W-1:0]  o_wait;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {o_wait, o_tag, o_slot, o_trk};

  // sequencer
  ltes_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // track state, event memory and arithmetic
  ltes_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_act       (s_tuser[3:0]),
    .in_trk       (s_tuser[5:4]),
    .in_slot      (s_tdata[5:0]),
    .in_ts        (s_tdata[37:6]),
    .in_tag       (s_tdata[53:38]),
    .in_last      (s_tlast),
    .in_len       (s_tdata[85:54]),
    .in_now       (s_tdata[133:86]),
    .in_keep      (s_tdata[134]),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_idx      (cfg_index),
    .cfg_val      (cfg_data),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_ev_valid (m_tuser),
    .out_trk      (o_trk),
    .out_slot     (o_slot),
    .out_tag      (o_tag),
    .out_wait     (o_wait)
  );

  // a result is only loaded when the output register can take it
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending transaction");

  // the shared divider is never restarted while busy
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider started while busy");

  // an accepted transaction is executed in the following cycle
  a_exec: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (cmd.exec && !s_tready))
    else $error("accepted action not executed");

endmodule
